>>> sv/ccc_pkg.sv
// Shared types and constants for the chunk view-cone cull test.
// No dependencies; every other file of the block refers to this package.
package ccc_pkg;

  // Default coordinate width in bits, Q.8 feet.
  localparam int unsigned COORD_BITS_DEF = 32;

  // Width of one input box field on the channel.
  localparam int unsigned FIELD_W = 32;

  // Limb width for the split wide multipliers.
  localparam int unsigned LIMB_W = 32;

  // Register index width on the configuration port.
  localparam int unsigned REG_IDX_W = 3;

  // Total register stages from input acceptance to the output register.
  localparam int unsigned PIPE_DEPTH = 12;

  // One foot squared in doubled Q.8 (Q.9) units.
  localparam int unsigned FLOOR_SHIFT = 18;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAMERA_X = 3'd0,
    REG_CAMERA_Y = 3'd1,
    REG_CAMERA_Z = 3'd2,
    REG_AIM_X    = 3'd3,
    REG_AIM_Y    = 3'd4,
    REG_AIM_Z    = 3'd5
  } ccc_reg_e;

  // Sign and bypass flags that travel beside the first products.
  typedef struct packed {
    logic [2:0] t_neg;
    logic [2:0] f_neg;
    logic       always_vis;
  } ccc_flags_t;

endpackage

>>> sv/ccc_if.sv
// Valid/ready channel interfaces for box items and visibility results.
// Depends on ccc_pkg for the field width.
interface ccc_box_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ccc_pkg::FIELD_W-1:0]      box_west;
  logic signed [ccc_pkg::FIELD_W-1:0]      box_east;
  logic signed [ccc_pkg::FIELD_W-1:0]      box_south;
  logic signed [ccc_pkg::FIELD_W-1:0]      box_north;
  logic signed [ccc_pkg::FIELD_W-1:0]      box_bottom;
  logic signed [ccc_pkg::FIELD_W-1:0]      box_top;

  modport source (output valid, box_west, box_east, box_south, box_north,
                  box_bottom, box_top, input ready);
  modport sink   (input valid, box_west, box_east, box_south, box_north,
                  box_bottom, box_top, output ready);
endinterface

interface ccc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

>>> sv/chunk_view_cone_cull_test.sv
// Top level of the chunk view-cone cull test: configuration registers,
// pipeline control, sums, wide products and the final compare.
// Depends on ccc_pkg, ccc_if, ccc_mul and ccc_front.
//
//   Channel   Direction  Payload                               Handshake
//   box_in    in         box_west..box_top, 32 b signed Q.8    valid/ready
//   vis_out   out        visible, 1 b                          valid/ready
//   cfg       in         cfg_idx_i, cfg_data_i                 cfg_we_i
//
// One box per cycle while the output does not stall; each passes 12 register
// stages (front, three chained 3-stage split multipliers, the sum stage and
// the output register), and its result is valid from the output register.
// Reset clears the stage valid bits and the camera and aim registers.
// A stall at the output holds every stage; ready is low only while the
// output register is full and not being taken.
module chunk_view_cone_cull_test #(
  parameter int unsigned COORD_BITS = ccc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ccc_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [COORD_BITS-1:0]               cfg_data_i,
  ccc_box_if.sink                             box_in,
  ccc_vis_if.source                           vis_out
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned TW  = CB + 3;
  localparam int unsigned FW  = CB + 1;
  localparam int unsigned SW  = CB + 1;
  localparam int unsigned PW  = TW + FW;
  localparam int unsigned DW  = PW + 2;
  localparam int unsigned TTW = 2 * TW + 2;
  localparam int unsigned FFW = 2 * FW + 2;
  localparam int unsigned SSW = 2 * SW + 2;
  localparam int unsigned STW = SSW + TTW;
  localparam int unsigned DDW = 2 * DW;
  localparam int unsigned LW  = STW + FFW;
  localparam int unsigned RW  = DDW + TTW;
  localparam int unsigned CW  = (LW > RW) ? LW : RW;
  localparam int unsigned ND  = ccc_pkg::PIPE_DEPTH;

  logic signed [CB-1:0] cam_q [3];
  logic signed [CB-1:0] aim_q [3];
  logic signed [CB-1:0] lo_v  [3];
  logic signed [CB-1:0] hi_v  [3];
  logic [ND-1:0]        vld_q;
  logic                 adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        cam_q[k] <= '0;
        aim_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (ccc_pkg::ccc_reg_e'(cfg_idx_i))
        ccc_pkg::REG_CAMERA_X: cam_q[0] <= cfg_data_i;
        ccc_pkg::REG_CAMERA_Y: cam_q[1] <= cfg_data_i;
        ccc_pkg::REG_CAMERA_Z: cam_q[2] <= cfg_data_i;
        ccc_pkg::REG_AIM_X:    aim_q[0] <= cfg_data_i;
        ccc_pkg::REG_AIM_Y:    aim_q[1] <= cfg_data_i;
        ccc_pkg::REG_AIM_Z:    aim_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipe moves when the output register is free or being taken.
  assign adv          = !vld_q[ND-1] || vis_out.ready;
  assign box_in.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ND-2:0], box_in.valid};
    end
  end

  // Box fields in the view-frame axis order: east, up, north.
  assign lo_v[0] = CB'(box_in.box_west);
  assign hi_v[0] = CB'(box_in.box_east);
  assign lo_v[1] = CB'(box_in.box_bottom);
  assign hi_v[1] = CB'(box_in.box_top);
  assign lo_v[2] = CB'(box_in.box_south);
  assign hi_v[2] = CB'(box_in.box_north);

  logic [TW-1:0]       tmag [3];
  logic [FW-1:0]       fmag [3];
  logic [SW-1:0]       smag [3];
  ccc_pkg::ccc_flags_t flags0;

  ccc_front #(.CB(CB)) u_front (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cam_i   (cam_q),
    .aim_i   (aim_q),
    .lo_i    (lo_v),
    .hi_i    (hi_v),
    .tmag_o  (tmag),
    .fmag_o  (fmag),
    .smag_o  (smag),
    .flags_o (flags0)
  );

  // First products: dot terms and the three squared lengths.
  logic [PW-1:0]    tf_p [3];
  logic [2*TW-1:0]  tt_p [3];
  logic [2*FW-1:0]  ff_p [3];
  logic [2*SW-1:0]  ss_p [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    ccc_mul #(.AW(TW), .BW(FW)) u_tf (
      .clk_i(clk_i), .en_i(adv), .a_i(tmag[k]), .b_i(fmag[k]), .p_o(tf_p[k]));
    ccc_mul #(.AW(TW), .BW(TW)) u_tt (
      .clk_i(clk_i), .en_i(adv), .a_i(tmag[k]), .b_i(tmag[k]), .p_o(tt_p[k]));
    ccc_mul #(.AW(FW), .BW(FW)) u_ff (
      .clk_i(clk_i), .en_i(adv), .a_i(fmag[k]), .b_i(fmag[k]), .p_o(ff_p[k]));
    ccc_mul #(.AW(SW), .BW(SW)) u_ss (
      .clk_i(clk_i), .en_i(adv), .a_i(smag[k]), .b_i(smag[k]), .p_o(ss_p[k]));
  end

  // Flags ride beside the first multipliers.
  ccc_pkg::ccc_flags_t fl_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl_q[0] <= flags0;
      fl_q[1] <= fl_q[0];
      fl_q[2] <= fl_q[1];
    end
  end

  // Signed dot product split into positive and negative sums.
  logic [DW-1:0]  pos_v, neg_v;
  logic [TTW-1:0] tt_v;
  logic [FFW-1:0] ff_v;
  logic [SSW-1:0] ss_v;
  logic           early_d;

  always_comb begin
    pos_v = '0;
    neg_v = '0;
    tt_v  = '0;
    ff_v  = '0;
    ss_v  = '0;
    for (int k = 0; k < 3; k++) begin
      if (fl_q[2].t_neg[k] == fl_q[2].f_neg[k]) begin
        pos_v = pos_v + DW'(tf_p[k]);
      end else begin
        neg_v = neg_v + DW'(tf_p[k]);
      end
      tt_v = tt_v + TTW'(tt_p[k]);
      ff_v = ff_v + FFW'(ff_p[k]);
      ss_v = ss_v + SSW'(ss_p[k]);
    end
    early_d = fl_q[2].always_vis || (pos_v > neg_v);
  end

  logic [DW-1:0]  dmag_q;
  logic [TTW-1:0] tt_q, m2_q;
  logic [FFW-1:0] ff_q;
  logic [SSW-1:0] ss_q;
  logic           early_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_q  <= neg_v - pos_v;
      tt_q    <= tt_v;
      m2_q    <= (tt_v >= (TTW'(1) << ccc_pkg::FLOOR_SHIFT)) ? tt_v
                                                             : (TTW'(1) << ccc_pkg::FLOOR_SHIFT);
      ff_q    <= ff_v;
      ss_q    <= ss_v;
      early_q <= early_d;
    end
  end

  // Second products: size by distance, and the squared dot.
  logic [STW-1:0] st_p;
  logic [DDW-1:0] dd_p;

  ccc_mul #(.AW(SSW), .BW(TTW)) u_st (
    .clk_i(clk_i), .en_i(adv), .a_i(ss_q), .b_i(tt_q), .p_o(st_p));
  ccc_mul #(.AW(DW), .BW(DW)) u_dd (
    .clk_i(clk_i), .en_i(adv), .a_i(dmag_q), .b_i(dmag_q), .p_o(dd_p));

  // Forward length, distance floor and early result wait for their partners.
  logic [FFW-1:0] ff_dq [3];
  logic [TTW-1:0] m2_dq [3];
  logic [5:0]     early_dq;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ff_dq[0] <= ff_q;
      m2_dq[0] <= m2_q;
      for (int k = 1; k < 3; k++) begin
        ff_dq[k] <= ff_dq[k-1];
        m2_dq[k] <= m2_dq[k-1];
      end
      early_dq <= {early_dq[4:0], early_q};
    end
  end

  // Third products: both sides of the scaled compare.
  logic [LW-1:0] lhs_p;
  logic [RW-1:0] rhs_p;

  ccc_mul #(.AW(STW), .BW(FFW)) u_lhs (
    .clk_i(clk_i), .en_i(adv), .a_i(st_p), .b_i(ff_dq[2]), .p_o(lhs_p));
  ccc_mul #(.AW(DDW), .BW(TTW)) u_rhs (
    .clk_i(clk_i), .en_i(adv), .a_i(dd_p), .b_i(m2_dq[2]), .p_o(rhs_p));

  // Output register.
  logic vis_q;
  logic early_out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q       <= early_dq[5] || (CW'(lhs_p) > CW'(rhs_p));
      early_out_q <= early_dq[5];
    end
  end

  assign vis_out.valid   = vld_q[ND-1];
  assign vis_out.visible = vis_q;

  // An accepted item always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_in.valid && box_in.ready |=> vld_q[0])
    else $error("accepted item missing from first stage");

  // A held pipe keeps every stage's valid bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("stage valid bits moved during a stall");

  // A bypassed item leaves as visible.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vis_out.valid && early_out_q |-> vis_out.visible)
    else $error("bypassed item reported not visible");

endmodule

>>> sv/ccc_mul.sv
// Pipelined wide unsigned multiplier built from 32 by 32 partial products.
// Three register stages: partial products, row sums, final sum. Uses ccc_pkg.
module ccc_mul #(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 64
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AW-1:0]        a_i,
  input  logic [BW-1:0]        b_i,
  output logic [AW+BW-1:0]     p_o
);

  localparam int unsigned L  = ccc_pkg::LIMB_W;
  localparam int unsigned NA = (AW + L - 1) / L;
  localparam int unsigned NB = (BW + L - 1) / L;
  localparam int unsigned PA = NA * L;
  localparam int unsigned PB = NB * L;
  localparam int unsigned RW = PA + L;
  localparam int unsigned SW = PA + PB;

  logic [PA-1:0]   a_ext;
  logic [PB-1:0]   b_ext;
  logic [2*L-1:0]  pp_d  [NA][NB];
  logic [2*L-1:0]  pp_q  [NA][NB];
  logic [RW-1:0]   row_d [NB];
  logic [RW-1:0]   row_q [NB];
  logic [SW-1:0]   sum_d;
  logic [SW-1:0]   sum_q;

  assign a_ext = PA'(a_i);
  assign b_ext = PB'(b_i);

  // Limb by limb products.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_d[i][j] = (2*L)'(a_ext[i*L +: L]) * (2*L)'(b_ext[j*L +: L]);
      end
    end
  end

  // One row per limb of b: the whole of a times that limb.
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_d[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_d[j] = row_d[j] + (RW'(pp_q[i][j]) << (i * L));
      end
    end
  end

  // Rows shifted into place and added.
  always_comb begin
    sum_d = '0;
    for (int j = 0; j < NB; j++) begin
      sum_d = sum_d + (SW'(row_q[j]) << (j * L));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q  <= pp_d;
      row_q <= row_d;
      sum_q <= sum_d;
    end
  end

  assign p_o = sum_q[AW+BW-1:0];

endmodule

>>> sv/ccc_front.sv
// First stage: forward vector, camera-to-centre vector and box sizes.
// Registers magnitudes and signs; uses ccc_pkg for the flag struct.
module ccc_front #(
  parameter int unsigned CB = ccc_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [CB-1:0]        cam_i  [3],
  input  logic signed [CB-1:0]        aim_i  [3],
  input  logic signed [CB-1:0]        lo_i   [3],
  input  logic signed [CB-1:0]        hi_i   [3],
  output logic [CB+2:0]               tmag_o [3],
  output logic [CB:0]                 fmag_o [3],
  output logic [CB:0]                 smag_o [3],
  output ccc_pkg::ccc_flags_t         flags_o
);

  localparam int unsigned TW = CB + 3;
  localparam int unsigned FW = CB + 1;
  localparam int unsigned SW = CB + 1;

  logic signed [TW-1:0] t_v [3];
  logic signed [FW-1:0] f_v [3];
  logic signed [SW-1:0] s_v [3];
  logic [TW-1:0]        tmag_q [3];
  logic [FW-1:0]        fmag_q [3];
  logic [SW-1:0]        smag_q [3];
  ccc_pkg::ccc_flags_t  flags_d;
  ccc_pkg::ccc_flags_t  flags_q;

  // Doubled centre minus doubled camera; on the north axis only the centre is negated.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_v[k] = FW'(aim_i[k]) - FW'(cam_i[k]);
      s_v[k] = SW'(hi_i[k]) - SW'(lo_i[k]);
    end
    t_v[0] = TW'(lo_i[0]) + TW'(hi_i[0]) - (TW'(cam_i[0]) <<< 1);
    t_v[1] = TW'(lo_i[1]) + TW'(hi_i[1]) - (TW'(cam_i[1]) <<< 1);
    t_v[2] = -(TW'(lo_i[2]) + TW'(hi_i[2])) - (TW'(cam_i[2]) <<< 1);
  end

  // A degenerate forward vector or an all-zero t_v vector always passes.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      flags_d.t_neg[k] = t_v[k][TW-1];
      flags_d.f_neg[k] = f_v[k][FW-1];
    end
    flags_d.always_vis = ((f_v[0] == '0) && (f_v[1] == '0) && (f_v[2] == '0)) ||
                         ((t_v[0] == '0) && (t_v[1] == '0) && (t_v[2] == '0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        tmag_q[k] <= t_v[k][TW-1] ? TW'(-t_v[k]) : TW'(t_v[k]);
        fmag_q[k] <= f_v[k][FW-1] ? FW'(-f_v[k]) : FW'(f_v[k]);
        smag_q[k] <= s_v[k][SW-1] ? SW'(-s_v[k]) : SW'(s_v[k]);
      end
      flags_q <= flags_d;
    end
  end

  assign tmag_o  = tmag_q;
  assign fmag_o  = fmag_q;
  assign smag_o  = smag_q;
  assign flags_o = flags_q;

endmodule
